// ===== src/lapr_pkg.sv =====
// Shared types and constants for the lossless audio predictor restore block.
// Used by lapr_cell, lapr_mac and lossless_audio_predictor_restore.
package lapr_pkg;

    localparam int MAX_ORDER   = 32;
    localparam int TAP_W       = $clog2(MAX_ORDER);
    localparam int ORDER_W     = 6;
    localparam int SAMPLE_W    = 33;
    localparam int COEF_W      = 15;
    localparam int RESID_W     = 32;
    localparam int RAW_W       = 33;
    localparam int SBITS_W     = 6;
    localparam int QSHIFT_W    = 4;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + TAP_W;
    localparam int FIX_W       = SAMPLE_W + 5;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int FIXED_MAX   = 4;

    typedef enum logic [1:0] {
        ACT_COEF   = 2'd0,
        ACT_WARMUP = 2'd1,
        ACT_RESID  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND   = 2'd0,
        CFG_ORDER  = 2'd1,
        CFG_QSHIFT = 2'd2,
        CFG_SBITS  = 2'd3
    } t_cfg_index;

    typedef enum logic [0:0] {
        KIND_FIXED = 1'b0,
        KIND_LPC   = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic push;
        logic rotate;
    } t_cell_ctl;

    typedef struct packed {
        logic clear;
        logic advance;
        logic take;
    } t_mac_ctl;

endpackage

// ===== src/lapr_cell.sv =====
// One tap cell: holds one history sample and one LPC coefficient.
// Shifts on push, rotates with its neighbor on a sweep. Depends on lapr_pkg.
module lapr_cell
    import lapr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_prev_hist,
    input  logic signed [SAMPLE_W-1:0] i_next_hist,
    input  logic signed [COEF_W-1:0]   i_next_coef,
    input  logic                       i_coef_wr,
    input  logic signed [COEF_W-1:0]   i_coef_data,
    output logic signed [SAMPLE_W-1:0] o_hist,
    output logic signed [COEF_W-1:0]   o_coef
);

    logic signed [SAMPLE_W-1:0] r_hist;
    logic signed [COEF_W-1:0]   r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctl.push) begin
                r_hist <= i_prev_hist;
            end else if (i_ctl.rotate) begin
                r_hist <= i_next_hist;
            end
            if (i_coef_wr) begin
                r_coef <= i_coef_data;
            end else if (i_ctl.rotate) begin
                r_coef <= i_next_coef;
            end
        end
    end

    assign o_hist = r_hist;
    assign o_coef = r_coef;

endmodule

// ===== src/lapr_mac.sv =====
// Shared multiply-accumulate for the LPC sum: one registered product per cycle
// while advance is set. Depends on lapr_pkg.
module lapr_mac
    import lapr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_hist,
    input  logic signed [COEF_W-1:0]   i_coef,
    output logic signed [ACC_W-1:0]    o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(i_hist) * PROD_W'(i_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else if (i_ctl.clear) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else if (i_ctl.advance) begin
            r_prod <= i_ctl.take ? w_prod : '0;
            r_acc  <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== src/lossless_audio_predictor_restore.sv =====
// Top level of the lossless audio predictor restore block.
// Instantiates the row of lapr_cell taps and lapr_mac. Depends on lapr_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item: a coefficient
//   load, a warm-up sample or a residual. Output channel (o_out_valid /
//   i_out_stall) carries one reconstructed sample per warm-up or residual.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes predictor kind,
//   order, quantization shift and sample width; write only while idle.
// Sequence:
//   Coefficient load: no result; the block stays idle.
//   Warm-up or fixed-predictor residual: the result is registered as the item
//   is taken, then moves from the done state into the output register.
//   LPC residual: the history and coefficients rotate through the row of
//   cells once past the single shared multiplier, then the sum drains, is
//   shifted and is added to the residual, and the result moves from the done
//   state into the output register.
//   One item is in work at a time; o_in_stall is high while it is.
// Reset: history, coefficients, state and configuration clear; sample width
//   returns to 16; result registers are not reset. When the receiver stalls,
//   the result holds in the output register; a finished item waits for it.
module lossless_audio_predictor_restore
    import lapr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_action,
    input  logic [TAP_W-1:0]           i_coef_index,
    input  logic signed [COEF_W-1:0]   i_coef_value,
    input  logic [RAW_W-1:0]           i_warmup_raw,
    input  logic signed [RESID_W-1:0]  i_residual,
    input  logic                       i_last_in_block,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_error,
    output logic                       o_last_sample,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_state                     r_state, n_state;
    logic                       r_kind;
    logic [ORDER_W-1:0]         r_order;
    logic [QSHIFT_W-1:0]        r_qshift;
    logic [SBITS_W-1:0]         r_sbits;
    logic [TAP_W-1:0]           r_tap;
    logic signed [SAMPLE_W-1:0] r_res;
    logic                       r_err;
    logic                       r_push;
    logic                       r_last;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_error;
    logic                       r_out_last;

    logic                       w_accept;
    logic                       w_slot_free;
    t_action                    w_action;
    t_cell_ctl                  w_cell_ctl;
    t_mac_ctl                   w_mac_ctl;
    logic                       w_tap_last;
    logic [ORDER_W-1:0]         w_ntaps;
    logic [SBITS_W-1:0]         w_bits;
    logic [SBITS_W-1:0]         w_sext_sh;
    logic [SAMPLE_W-1:0]        w_raw_up;
    logic signed [SAMPLE_W-1:0] w_warm;
    logic signed [FIX_W-1:0]    w_h0, w_h1, w_h2, w_h3, w_fpred, w_fsum;
    logic                       w_fix_bad;
    logic signed [ACC_W-1:0]    w_acc;
    logic signed [ACC_W-1:0]    w_pred;

    logic signed [SAMPLE_W-1:0] w_hist [MAX_ORDER];
    logic signed [COEF_W-1:0]   w_coef [MAX_ORDER];

    assign w_action    = t_action'(i_action);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_tap_last  = (r_tap == TAP_W'(MAX_ORDER - 1));
    assign w_ntaps     = (r_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : r_order;
    assign o_cfg_ready = 1'b1;

    // Row of tap cells
    genvar j;
    generate
        for (j = 0; j < MAX_ORDER; j++) begin : g_cell
            logic w_wr;
            assign w_wr = w_accept && (w_action == ACT_COEF)
                          && (i_coef_index == TAP_W'(j));
            lapr_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_cell_ctl),
                .i_prev_hist ((j == 0) ? r_res : w_hist[(j + MAX_ORDER - 1) % MAX_ORDER]),
                .i_next_hist (w_hist[(j + 1) % MAX_ORDER]),
                .i_next_coef (w_coef[(j + 1) % MAX_ORDER]),
                .i_coef_wr   (w_wr),
                .i_coef_data (i_coef_value),
                .o_hist      (w_hist[j]),
                .o_coef      (w_coef[j])
            );
        end
    endgenerate

    lapr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_hist  (w_hist[0]),
        .i_coef  (w_coef[0]),
        .o_acc   (w_acc)
    );

    // Warm-up sign extension
    always_comb begin
        if (r_sbits == '0) begin
            w_bits = SBITS_W'(1);
        end else if (r_sbits > SBITS_W'(SAMPLE_W)) begin
            w_bits = SBITS_W'(SAMPLE_W);
        end else begin
            w_bits = r_sbits;
        end
        w_sext_sh = SBITS_W'(SAMPLE_W) - w_bits;
        w_raw_up  = i_warmup_raw << w_sext_sh;
        w_warm    = $signed(w_raw_up) >>> w_sext_sh;
    end

    // Fixed polynomial prediction
    always_comb begin
        w_h0 = FIX_W'(w_hist[0]);
        w_h1 = FIX_W'(w_hist[1]);
        w_h2 = FIX_W'(w_hist[2]);
        w_h3 = FIX_W'(w_hist[3]);
        w_fix_bad = 1'b0;
        case (r_order)
            6'd0:    w_fpred = '0;
            6'd1:    w_fpred = w_h0;
            6'd2:    w_fpred = (w_h0 <<< 1) - w_h1;
            6'd3:    w_fpred = FIX_W'(3) * w_h0 - FIX_W'(3) * w_h1 + w_h2;
            6'd4:    w_fpred = (w_h0 <<< 2) - FIX_W'(6) * w_h1 + (w_h2 <<< 2) - w_h3;
            default: begin
                w_fpred   = '0;
                w_fix_bad = 1'b1;
            end
        endcase
        w_fsum = FIX_W'(i_residual) + w_fpred;
    end

    assign w_pred = w_acc >>> r_qshift;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_action == ACT_WARMUP) begin
                        n_state = ST_DONE;
                    end else if (w_action == ACT_RESID) begin
                        n_state = (r_kind == KIND_LPC) ? ST_RUN : ST_DONE;
                    end
                end
            end
            ST_RUN:    n_state = w_tap_last ? ST_DRAIN : ST_RUN;
            ST_DRAIN:  n_state = ST_FINISH;
            ST_FINISH: n_state = ST_DONE;
            ST_DONE:   n_state = w_slot_free ? ST_IDLE : ST_DONE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_in_stall        = (r_state != ST_IDLE);
        w_cell_ctl.rotate = (r_state == ST_RUN);
        w_cell_ctl.push   = (r_state == ST_DONE) && w_slot_free && r_push;
        w_mac_ctl.clear   = w_accept && (w_action == ACT_RESID) && (r_kind == KIND_LPC);
        w_mac_ctl.advance = (r_state == ST_RUN) || (r_state == ST_DRAIN);
        w_mac_ctl.take    = (r_state == ST_RUN) && (ORDER_W'(r_tap) < w_ntaps);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= KIND_FIXED;
            r_order     <= '0;
            r_qshift    <= '0;
            r_sbits     <= SBITS_W'(16);
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_KIND:   r_kind   <= i_cfg_data[0];
                    CFG_ORDER:  r_order  <= i_cfg_data[ORDER_W-1:0];
                    CFG_QSHIFT: r_qshift <= i_cfg_data[QSHIFT_W-1:0];
                    CFG_SBITS:  r_sbits  <= i_cfg_data[SBITS_W-1:0];
                    default:    r_kind   <= r_kind;
                endcase
            end
            if (r_state == ST_RUN) begin
                r_tap <= r_tap + TAP_W'(1);
            end else begin
                r_tap <= '0;
            end
            if ((r_state == ST_DONE) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result and output payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && w_accept) begin
            r_last <= i_last_in_block;
            r_err  <= 1'b0;
            r_push <= 1'b1;
            if (w_action == ACT_WARMUP) begin
                r_res <= w_warm;
            end else if (r_kind == KIND_LPC) begin
                r_res <= SAMPLE_W'(i_residual);
            end else if (w_fix_bad) begin
                r_res  <= '0;
                r_err  <= 1'b1;
                r_push <= 1'b0;
            end else begin
                r_res <= w_fsum[SAMPLE_W-1:0];
            end
        end else if (r_state == ST_FINISH) begin
            r_res <= r_res + w_pred[SAMPLE_W-1:0];
        end
        if ((r_state == ST_DONE) && w_slot_free) begin
            r_out_sample <= r_res;
            r_out_error  <= r_err;
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample      = r_out_sample;
    assign o_error       = r_out_error;
    assign o_last_sample = r_out_last;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("output valid rose outside the done state");

    a_sweep_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && w_tap_last) |=> r_state == ST_DRAIN)
        else $error("tap sweep did not end after the last tap");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> o_sample == '0)
        else $error("error result carries a nonzero sample");

    a_coef_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_action == ACT_COEF) |=> r_state == ST_IDLE)
        else $error("coefficient load left the idle state");

    a_no_push_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_err) |-> !w_cell_ctl.push)
        else $error("history pushed for an error result");

endmodule
